// ===== design/vmhsp_pkg.sv =====
// shared opcodes, status codes, config indexes and types for the heap/stack pointer unit
`default_nettype none

package vmhsp_pkg;

    // field widths fixed by the interface
    localparam int CELL_W      = 32;
    localparam int OPCODE_W    = 3;
    localparam int STATUS_W    = 3;
    localparam int DATA_SIZE_W = 16;
    localparam int MEM_SIZE_W  = 17;
    localparam int CFG_IDX_W   = 1;

    // smallest room kept between static data and the stack top
    localparam int MIN_HEAP = 16384;

    // opcodes
    localparam logic [OPCODE_W-1:0] OP_PUSH       = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_POP        = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_HEAP_ALLOC = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_ADD_STACK  = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_READ       = 3'd4;
    localparam logic [OPCODE_W-1:0] OP_WRITE      = 3'd5;
    localparam logic [OPCODE_W-1:0] OP_ENTER      = 3'd6;
    localparam logic [OPCODE_W-1:0] OP_LEAVE      = 3'd7;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_STACK_LOW = 3'd1;
    localparam logic [STATUS_W-1:0] ST_STACK_MIN = 3'd2;
    localparam logic [STATUS_W-1:0] ST_HEAP_LOW  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_HEAP_MIN  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_BAD_ADDR  = 3'd5;

    // config register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DATA_SIZE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MEM_SIZE  = 1'b1;

    // config reset values
    localparam logic [DATA_SIZE_W-1:0] DATA_SIZE_RST = 16'd0;
    localparam logic [MEM_SIZE_W-1:0]  MEM_SIZE_RST  = 17'd65536;

    // cell memory command
    typedef struct packed {
        logic rd;
        logic wr;
    } t_mem_ctl;

endpackage

`default_nettype wire

// ===== design/vmhsp_cell_mem.sv =====
// byte-banked cell memory: unaligned 4-byte little-endian access, clearing pass after reset
`default_nettype none

module vmhsp_cell_mem #(
    parameter int AW = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire vmhsp_pkg::t_mem_ctl           i_ctl,
    input  wire logic [AW-1:0]                 i_addr,
    input  wire logic [vmhsp_pkg::CELL_W-1:0]  i_wdata,
    output logic [vmhsp_pkg::CELL_W-1:0]       o_rdata,
    output logic                               o_busy
);

    localparam int RW   = AW - 2;
    localparam int ROWS = 1 << RW;

    logic [RW-1:0] r_clr_row;
    logic          r_busy;
    logic [1:0]    r_off;
    logic [7:0]    w_rd_byte [4];

    // clearing pass, one row of all four banks per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b1;
            r_clr_row <= '0;
        end else if (r_busy) begin
            r_clr_row <= r_clr_row + RW'(1);
            if (&r_clr_row) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;

    // byte offset of the cell, kept for the read rotation
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd) begin
            r_off <= i_addr[1:0];
        end
    end

    // bank b holds the bytes whose address is b modulo four
    for (genvar b = 0; b < 4; b++) begin : g_bank
        logic [7:0]    r_mem [ROWS];
        logic [7:0]    r_rd;
        logic [1:0]    w_sel;
        logic [AW-1:0] w_byte_addr;
        logic [RW-1:0] w_row;
        logic          w_we;
        logic [RW-1:0] w_wrow;
        logic [7:0]    w_wdat;

        // which byte of the cell lands in this bank, and at which row
        assign w_sel       = 2'(b) - i_addr[1:0];
        assign w_byte_addr = i_addr + {{(AW-2){1'b0}}, w_sel};
        assign w_row       = w_byte_addr[AW-1:2];

        // clearing pass takes the write port
        assign w_we   = r_busy | i_ctl.wr;
        assign w_wrow = r_busy ? r_clr_row : w_row;
        assign w_wdat = r_busy ? 8'd0 : i_wdata[8*w_sel +: 8];

        always_ff @(posedge i_clk) begin
            if (w_we) begin
                r_mem[w_wrow] <= w_wdat;
            end
            if (i_ctl.rd) begin
                r_rd <= r_mem[w_row];
            end
        end

        assign w_rd_byte[b] = r_rd;
    end

    // rotate bank bytes back into cell order
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            o_rdata[8*i +: 8] = w_rd_byte[r_off + 2'(i)];
        end
    end

endmodule

`default_nettype wire

// ===== design/vm_heap_stack_pointer_unit.sv =====
// Heap/stack pointer unit: push, heap alloc, add stack, write and enter scope register their result
// at acceptance; pop, read and leave scope pass through the read state first, waiting on the
// registered read of the cell memory. Throughput is one transaction per cycle while the output is
// not stalled, and the reading opcodes hold off the next transaction until their data returns.
// After reset the memory is zeroed by a clearing pass over all its rows during which no
// transaction is taken; pointers reload from the config registers on reset and writes.
`default_nettype none

module vm_heap_stack_pointer_unit #(
    parameter int MEM_BYTES    = 65536,  // power of two
    parameter int STACK_MARGIN = 64
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    // config write port
    input  wire logic                                   i_cfg_we,
    input  wire logic [vmhsp_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  wire logic [vmhsp_pkg::MEM_SIZE_W-1:0]       i_cfg_data,
    // input channel
    input  wire logic                                   i_in_valid,
    output logic                                        o_in_ready,
    input  wire logic [vmhsp_pkg::OPCODE_W-1:0]         i_opcode,
    input  wire logic signed [vmhsp_pkg::CELL_W-1:0]    i_address,
    input  wire logic signed [vmhsp_pkg::CELL_W-1:0]    i_value,
    input  wire logic signed [vmhsp_pkg::CELL_W-1:0]    i_amount,
    // output channel
    output logic                                        o_out_valid,
    input  wire logic                                   i_out_ready,
    output logic [vmhsp_pkg::STATUS_W-1:0]              o_status,
    output logic signed [vmhsp_pkg::CELL_W-1:0]         o_result_value
);

    localparam int AW = $clog2(MEM_BYTES);
    localparam int SW = AW + 2;
    localparam int XW = ((AW + 2 > 32) ? AW + 2 : 32) + 2;
    localparam int CW = ((AW > 17) ? AW : 17) + 2;
    localparam int DW = vmhsp_pkg::CELL_W;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_READ = 1'b1;

    localparam logic signed [XW-1:0] MARGIN_X = XW'(STACK_MARGIN);
    localparam logic signed [XW-1:0] FOUR_X   = XW'(4);
    localparam logic [CW-1:0] CAP_C  = CW'(MEM_BYTES - vmhsp_pkg::MIN_HEAP);
    localparam logic [CW-1:0] MIN_C  = CW'(vmhsp_pkg::MIN_HEAP);
    localparam logic [CW-1:0] TOP_C  = CW'(MEM_BYTES);
    localparam logic [SW-1:0] SH_NIL = '1;
    localparam logic [SW-1:0] SH_MIN = {1'b1, {(SW-1){1'b0}}};
    localparam logic [SW-1:0] SH_MAX = {1'b0, {(SW-1){1'b1}}};

    // config and pointer state
    logic [vmhsp_pkg::DATA_SIZE_W-1:0] r_ds, n_ds;
    logic [vmhsp_pkg::MEM_SIZE_W-1:0]  r_ms, n_ms;
    logic [AW-1:0] r_dsz, r_stp, r_ht, r_sp;
    logic [AW-1:0] n_ht, n_sp;
    logic [SW-1:0] r_sh, n_sh;
    logic [AW-1:0] w_dsz_new, w_stp_new;
    logic          w_cfg_load;

    // sequencer and output register
    logic                               r_state, n_state;
    logic [vmhsp_pkg::OPCODE_W-1:0]     r_op;
    logic                               r_out_valid, n_out_valid;
    logic [vmhsp_pkg::STATUS_W-1:0]     r_status, n_status;
    logic [DW-1:0]                      r_result, n_result;
    logic                               w_accept;

    // memory side
    vmhsp_pkg::t_mem_ctl w_mem_ctl;
    logic [AW-1:0]       w_mem_addr;
    logic [DW-1:0]       w_mem_wdata;
    logic [DW-1:0]       w_mem_rdata;
    logic                w_mem_busy;

    // widened operands
    logic signed [XW-1:0] w_ht_x, w_sp_x, w_stp_x, w_dsz_x, w_sh_x;
    logic signed [XW-1:0] w_amt_x, w_addr_x, w_amt_sel, w_heap_new, w_stack_new;
    logic signed [XW-1:0] w_link_x;
    logic [SW-1:0]        w_link;

    function automatic logic signed [XW-1:0] f_ptr_x(input logic [AW-1:0] p);
        f_ptr_x = signed'({{(XW-AW){1'b0}}, p});
    endfunction

    // address rejected: negative, in the heap/stack gap, or at or above the stack top
    function automatic logic f_bad(
        input logic signed [XW-1:0] a,
        input logic signed [XW-1:0] ht,
        input logic signed [XW-1:0] sp,
        input logic signed [XW-1:0] stp
    );
        f_bad = (a < 0) || ((a >= ht) && (a < sp)) || (a >= stp);
    endfunction

    // next config values, reset values while in reset
    always_comb begin
        n_ds = r_ds;
        n_ms = r_ms;
        if (!i_rst_n) begin
            n_ds = vmhsp_pkg::DATA_SIZE_RST;
            n_ms = vmhsp_pkg::MEM_SIZE_RST;
        end else if (i_cfg_we && i_cfg_idx == vmhsp_pkg::CFG_DATA_SIZE) begin
            n_ds = i_cfg_data[vmhsp_pkg::DATA_SIZE_W-1:0];
        end else if (i_cfg_we && i_cfg_idx == vmhsp_pkg::CFG_MEM_SIZE) begin
            n_ms = i_cfg_data;
        end
    end

    assign w_cfg_load = !i_rst_n || i_cfg_we;

    // effective data size and stack top from the config values
    always_comb begin
        logic [CW-1:0] dsz;
        logic [CW-1:0] m;
        logic [CW-1:0] m_up;
        logic [CW-1:0] m_min;
        dsz   = CW'(n_ds);
        if (dsz > CAP_C) begin
            dsz = CAP_C;
        end
        m     = CW'(n_ms);
        if (m < dsz) begin
            m = dsz;
        end
        m_up  = m + CW'(3);
        m     = {m_up[CW-1:2], 2'b00};
        m_min = dsz + MIN_C;
        if (m < m_min) begin
            m = m_min;
        end
        if (m > TOP_C) begin
            m = TOP_C;
        end
        m         = m - CW'(4);
        w_dsz_new = dsz[AW-1:0];
        w_stp_new = m[AW-1:0];
    end

    // widened views of pointers and inputs
    assign w_ht_x   = f_ptr_x(r_ht);
    assign w_sp_x   = f_ptr_x(r_sp);
    assign w_stp_x  = f_ptr_x(r_stp);
    assign w_dsz_x  = f_ptr_x(r_dsz);
    assign w_sh_x   = signed'({{(XW-SW){r_sh[SW-1]}}, r_sh});
    assign w_amt_x  = signed'({{(XW-DW){i_amount[DW-1]}}, i_amount});
    assign w_addr_x = signed'({{(XW-DW){i_address[DW-1]}}, i_address});

    assign w_amt_sel   = (i_opcode == vmhsp_pkg::OP_ENTER) ? FOUR_X : w_amt_x;
    assign w_heap_new  = w_ht_x + w_amt_sel;
    assign w_stack_new = w_sp_x + w_amt_x;

    // scope link from memory, saturated to the scope head range
    always_comb begin
        if ((&w_mem_rdata[DW-1:SW-1]) || !(|w_mem_rdata[DW-1:SW-1])) begin
            w_link = w_mem_rdata[SW-1:0];
        end else if (w_mem_rdata[DW-1]) begin
            w_link = SH_MIN;
        end else begin
            w_link = SH_MAX;
        end
    end

    assign w_link_x = signed'({{(XW-SW){w_link[SW-1]}}, w_link});

    // a transaction is taken only when the result register will be free for it
    assign o_in_ready = (r_state == S_IDLE) && !w_mem_busy && (!r_out_valid || i_out_ready);
    assign w_accept   = i_in_valid && o_in_ready;

    // operation sequencer: checks and pointer updates at acceptance, cell data in the following cycle;
    // one transaction at a time so a read never overlaps a write to the same bytes
    always_comb begin
        logic produce;
        n_state     = r_state;
        n_ht        = r_ht;
        n_sp        = r_sp;
        n_sh        = r_sh;
        n_status    = r_status;
        n_result    = r_result;
        produce     = 1'b0;
        w_mem_ctl   = '0;
        w_mem_addr  = '0;
        w_mem_wdata = i_value;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    produce  = 1'b1;
                    n_status = vmhsp_pkg::ST_OK;
                    n_result = '0;
                    case (i_opcode)
                        vmhsp_pkg::OP_PUSH: begin
                            if (w_sp_x <= w_ht_x + FOUR_X) begin
                                n_status = vmhsp_pkg::ST_STACK_LOW;
                            end else begin
                                n_sp          = r_sp - AW'(4);
                                w_mem_ctl.wr  = 1'b1;
                                w_mem_addr    = r_sp - AW'(4);
                            end
                        end
                        vmhsp_pkg::OP_POP: begin
                            if (w_sp_x >= w_stp_x) begin
                                n_status = vmhsp_pkg::ST_STACK_MIN;
                            end else begin
                                n_sp         = r_sp + AW'(4);
                                w_mem_ctl.rd = 1'b1;
                                w_mem_addr   = r_sp;
                                produce      = 1'b0;
                                n_state      = S_READ;
                            end
                        end
                        vmhsp_pkg::OP_HEAP_ALLOC, vmhsp_pkg::OP_ENTER: begin
                            if (w_amt_sel[XW-1] && w_heap_new < w_dsz_x) begin
                                n_status = vmhsp_pkg::ST_HEAP_MIN;
                            end else if (!w_amt_sel[XW-1] &&
                                         (w_heap_new + MARGIN_X > w_sp_x)) begin
                                n_status = vmhsp_pkg::ST_HEAP_LOW;
                            end else begin
                                n_result = DW'(r_ht);
                                n_ht     = w_heap_new[AW-1:0];
                                if (i_opcode == vmhsp_pkg::OP_ENTER) begin
                                    w_mem_ctl.wr = 1'b1;
                                    w_mem_addr   = r_ht;
                                    w_mem_wdata  = {{(DW-SW){r_sh[SW-1]}}, r_sh};
                                    n_sh         = SW'(r_ht);
                                end
                            end
                        end
                        vmhsp_pkg::OP_ADD_STACK: begin
                            if (w_amt_x[XW-1] && (w_stack_new < w_ht_x + MARGIN_X)) begin
                                n_status = vmhsp_pkg::ST_STACK_LOW;
                            end else if (!w_amt_x[XW-1] && (w_stack_new > w_stp_x)) begin
                                n_status = vmhsp_pkg::ST_STACK_MIN;
                            end else begin
                                n_sp = w_stack_new[AW-1:0];
                            end
                        end
                        vmhsp_pkg::OP_READ: begin
                            if (f_bad(w_addr_x, w_ht_x, w_sp_x, w_stp_x)) begin
                                n_status = vmhsp_pkg::ST_BAD_ADDR;
                            end else begin
                                w_mem_ctl.rd = 1'b1;
                                w_mem_addr   = i_address[AW-1:0];
                                produce      = 1'b0;
                                n_state      = S_READ;
                            end
                        end
                        vmhsp_pkg::OP_WRITE: begin
                            if (f_bad(w_addr_x, w_ht_x, w_sp_x, w_stp_x)) begin
                                n_status = vmhsp_pkg::ST_BAD_ADDR;
                            end else begin
                                w_mem_ctl.wr = 1'b1;
                                w_mem_addr   = i_address[AW-1:0];
                            end
                        end
                        default: begin
                            // leave scope
                            if (f_bad(w_sh_x, w_ht_x, w_sp_x, w_stp_x)) begin
                                n_status = vmhsp_pkg::ST_BAD_ADDR;
                            end else begin
                                w_mem_ctl.rd = 1'b1;
                                w_mem_addr   = r_sh[AW-1:0];
                                produce      = 1'b0;
                                n_state      = S_READ;
                            end
                        end
                    endcase
                end
            end
            default: begin
                // cell data has arrived
                produce  = 1'b1;
                n_state  = S_IDLE;
                n_status = vmhsp_pkg::ST_OK;
                n_result = '0;
                case (r_op)
                    vmhsp_pkg::OP_POP, vmhsp_pkg::OP_READ: begin
                        n_result = w_mem_rdata;
                    end
                    default: begin
                        // unlink: heap drops to the scope cell, head follows the stored link
                        n_ht = r_sh[AW-1:0];
                        n_sh = w_link;
                        if (w_link != SH_NIL && f_bad(w_link_x, w_sh_x, w_sp_x, w_stp_x)) begin
                            n_status = vmhsp_pkg::ST_BAD_ADDR;
                        end
                    end
                endcase
            end
        endcase

        // result register handshake
        n_out_valid = r_out_valid && !i_out_ready;
        if (produce) begin
            n_out_valid = 1'b1;
        end
    end

    // control and pointer registers
    always_ff @(posedge i_clk) begin
        r_ds <= n_ds;
        r_ms <= n_ms;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        if (w_cfg_load) begin
            r_dsz <= w_dsz_new;
            r_stp <= w_stp_new;
            r_ht  <= w_dsz_new;
            r_sp  <= w_stp_new;
            r_sh  <= SH_NIL;
        end else begin
            r_ht <= n_ht;
            r_sp <= n_sp;
            r_sh <= n_sh;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_result <= n_result;
        if (w_accept) begin
            r_op <= i_opcode;
        end
    end

    // cell memory
    vmhsp_cell_mem #(
        .AW (AW)
    ) u_cell_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_mem_ctl),
        .i_addr  (w_mem_addr),
        .i_wdata (w_mem_wdata),
        .o_rdata (w_mem_rdata),
        .o_busy  (w_mem_busy)
    );

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_result_value = signed'(r_result);

endmodule

`default_nettype wire
